>>> rtl/core/isophotal_flux_magnitude_unit_macros.svh
// Assertion macros shared by the isophotal flux and magnitude unit
`ifndef ISOPHOTAL_FLUX_MAGNITUDE_UNIT_MACROS_SVH
`define ISOPHOTAL_FLUX_MAGNITUDE_UNIT_MACROS_SVH

// check a property on every clock edge outside reset
`define IFMU_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define IFMU_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ifmu_pkg.sv
// Package: constants, datapath operation codes and status types of the flux unit
`default_nettype none
package ifmu_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int LOG_FRAC     = 24;
   localparam int MAG_SHIFT    = LOG_FRAC + 32 - FRAC_BITS;
   localparam int SQRT_STEPS   = (64 + FRAC_BITS + 1) / 2;
   localparam int LOG_STEPS    = LOG_FRAC;
   localparam int DIV_STEPS    = 47 + 25 + FRAC_BITS;
   localparam int CNT_W        = 7;

   localparam logic [31:0] MAG_PER_LOG2 = 32'd3232284966;
   localparam logic [24:0] ERR_COEF     = 25'd18215023;
   localparam logic signed [23:0] MAG_NONE = 24'sd6488064;

   localparam logic [1:0] REG_USE_WEIGHT = 2'd0;
   localparam logic [1:0] REG_WEIGHT_ABS = 2'd1;
   localparam logic [1:0] REG_BG_RMS     = 2'd2;
   localparam logic [1:0] REG_ZERO_POINT = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_BGVAR,
      OP_PROD,
      OP_VAR,
      OP_ACC,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_NORM_INIT,
      OP_NORM_STEP,
      OP_LOG_INIT,
      OP_LOG_STEP,
      OP_MAG_MUL,
      OP_MAG_FIN,
      OP_ERR_MUL,
      OP_ERR_COMB,
      OP_DIV_STEP,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic flux_pos;
      logic flux_zero;
      logic norm_done;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/core/ifmu_chan_if.sv
// Request and response channel interfaces of the flux unit
`default_nettype none
interface ifmu_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pixel_value;
   logic [31:0]        weight_value;
   logic               last_pixel;
   modport source (output valid, pixel_value, weight_value, last_pixel, input ready);
   modport sink   (input valid, pixel_value, weight_value, last_pixel, output ready);
endinterface

interface ifmu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] iso_flux;
   logic [46:0]        iso_flux_err;
   logic signed [23:0] magnitude;
   logic signed [31:0] magnitude_error;
   modport source (output valid, iso_flux, iso_flux_err, magnitude, magnitude_error,
                   input ready);
   modport sink   (input valid, iso_flux, iso_flux_err, magnitude, magnitude_error,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/core/isophotal_flux_magnitude_unit.sv
// Top level of the isophotal flux and magnitude unit
//
// Pixels of one source arrive as requests; each pixel passes in turn through its steps
// (accept, background variance multiply, weight partial products, combine, accumulate),
// and the next pixel is taken only after that. After a last pixel the unit runs a
// 40-step square root, a leading-one search and a 24-step log2 squaring loop (both
// skipped for non-positive flux), and an 88-step restoring divider (skipped for zero
// flux). The result sits in an output register: pixels of the next source are
// taken while it waits, and the unit stalls only if a second result is ready first.
`default_nettype none
module isophotal_flux_magnitude_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   ifmu_req_if.sink    req_chan,
   ifmu_rsp_if.source  rsp_chan
);
   ifmu_pkg::cmd_type    cmd;
   ifmu_pkg::status_type sts;

   ifmu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ifmu_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .pixel_value         (req_chan.pixel_value),
      .weight_value        (req_chan.weight_value),
      .last_pixel          (req_chan.last_pixel),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_iso_flux        (rsp_chan.iso_flux),
      .rsp_iso_flux_err    (rsp_chan.iso_flux_err),
      .rsp_magnitude       (rsp_chan.magnitude),
      .rsp_magnitude_error (rsp_chan.magnitude_error)
   );
endmodule
`default_nettype wire

>>> rtl/core/ifmu_ctrl.sv
// Controller: sequences the datapath through accumulation, root, log and divide
`default_nettype none
module ifmu_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire ifmu_pkg::status_type sts,
   output ifmu_pkg::cmd_type        cmd
);
   typedef enum logic [4:0] {
      ST_IDLE, ST_BGV, ST_PROD, ST_VAR, ST_ACC, ST_SQI, ST_SQS, ST_NRI, ST_NRS,
      ST_LGI, ST_LGS, ST_MGM, ST_MGF, ST_ERM, ST_ERC, ST_DVS, ST_FIN
   } state_type;

   state_type                     state_ff;
   logic [ifmu_pkg::CNT_W-1:0]    cnt_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.op = ifmu_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: if (req_valid) cmd.op = ifmu_pkg::OP_LOAD;
         ST_BGV:  cmd.op = ifmu_pkg::OP_BGVAR;
         ST_PROD: cmd.op = ifmu_pkg::OP_PROD;
         ST_VAR:  cmd.op = ifmu_pkg::OP_VAR;
         ST_ACC:  cmd.op = ifmu_pkg::OP_ACC;
         ST_SQI:  cmd.op = ifmu_pkg::OP_SQRT_INIT;
         ST_SQS:  cmd.op = ifmu_pkg::OP_SQRT_STEP;
         ST_NRI:  cmd.op = ifmu_pkg::OP_NORM_INIT;
         ST_NRS:  if (!sts.norm_done) cmd.op = ifmu_pkg::OP_NORM_STEP;
         ST_LGI:  cmd.op = ifmu_pkg::OP_LOG_INIT;
         ST_LGS:  cmd.op = ifmu_pkg::OP_LOG_STEP;
         ST_MGM:  cmd.op = ifmu_pkg::OP_MAG_MUL;
         ST_MGF:  cmd.op = ifmu_pkg::OP_MAG_FIN;
         ST_ERM:  cmd.op = ifmu_pkg::OP_ERR_MUL;
         ST_ERC:  cmd.op = ifmu_pkg::OP_ERR_COMB;
         ST_DVS:  cmd.op = ifmu_pkg::OP_DIV_STEP;
         ST_FIN:  if (sts.out_free) cmd.op = ifmu_pkg::OP_FINISH;
         default: cmd.op = ifmu_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: if (req_valid) state_ff <= ST_BGV;
            ST_BGV:  state_ff <= ST_PROD;
            ST_PROD: state_ff <= ST_VAR;
            ST_VAR:  state_ff <= ST_ACC;
            ST_ACC:  state_ff <= sts.last ? ST_SQI : ST_IDLE;
            ST_SQI: begin
               cnt_ff   <= '0;
               state_ff <= ST_SQS;
            end
            ST_SQS: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == ifmu_pkg::CNT_W'(ifmu_pkg::SQRT_STEPS - 1))
                  state_ff <= sts.flux_pos ? ST_NRI : ST_ERM;
            end
            ST_NRI:  state_ff <= ST_NRS;
            ST_NRS:  if (sts.norm_done) state_ff <= ST_LGI;
            ST_LGI: begin
               cnt_ff   <= '0;
               state_ff <= ST_LGS;
            end
            ST_LGS: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == ifmu_pkg::CNT_W'(ifmu_pkg::LOG_STEPS - 1)) state_ff <= ST_MGM;
            end
            ST_MGM:  state_ff <= ST_MGF;
            ST_MGF:  state_ff <= ST_ERM;
            ST_ERM:  state_ff <= ST_ERC;
            ST_ERC: begin
               cnt_ff   <= '0;
               state_ff <= sts.flux_zero ? ST_FIN : ST_DVS;
            end
            ST_DVS: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == ifmu_pkg::CNT_W'(ifmu_pkg::DIV_STEPS - 1)) state_ff <= ST_FIN;
            end
            ST_FIN:  if (sts.out_free) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/ifmu_dp.sv
// Datapath: sums, variance products, root, log, magnitude and error divider
`default_nettype none
`include "isophotal_flux_magnitude_unit_macros.svh"
module ifmu_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [31:0]         csr_wdata,
   input  wire logic signed [31:0]  pixel_value,
   input  wire logic [31:0]         weight_value,
   input  wire logic                last_pixel,
   input  wire ifmu_pkg::cmd_type   cmd,
   output ifmu_pkg::status_type     sts,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [47:0]       rsp_iso_flux,
   output logic [46:0]              rsp_iso_flux_err,
   output logic signed [23:0]       rsp_magnitude,
   output logic signed [31:0]       rsp_magnitude_error
);
   logic                use_w_ff, w_abs_ff;
   logic [31:0]         rms_ff;
   logic signed [23:0]  zp_ff;
   logic signed [47:0]  flux_ff, flux_in;
   logic [63:0]         vsum_ff, vsum_in;
   logic [31:0]         w_ff;
   logic                last_ff;
   logic [47:0]         bgv_ff, bgv_in;
   logic [63:0]         plo_ff;
   logic [47:0]         phi_ff;
   logic [63:0]         var_ff, var_in;
   logic [79:0]         sqop_ff;
   logic [39:0]         root_ff;
   logic [42:0]         srem_ff;
   logic [42:0]         srem_t, strial;
   logic [47:0]         xs_ff;
   logic [5:0]          n_ff;
   logic [30:0]         m_ff;
   logic [23:0]         frac_ff;
   logic [61:0]         msq;
   logic signed [30:0]  lg;
   logic signed [63:0]  mprod_ff;
   logic signed [23:0]  mag_ff, mag_in;
   logic [39:0]         eph_ff;
   logic [56:0]         epl_ff;
   logic [87:0]         dvd_ff;
   logic [47:0]         d_ff;
   logic [47:0]         drem_ff;
   logic [48:0]         drem_t;
   logic [63:0]         q_ff;
   logic                qsat_ff;
   logic                ovalid_ff;
   logic signed [47:0]  oflux_ff;
   logic [46:0]         oerr_ff;
   logic signed [23:0]  omag_ff;
   logic signed [31:0]  omerr_ff, omerr_in;
   logic                flux_pos, flux_zero;

   assign flux_zero = (flux_ff == '0);
   assign flux_pos  = !flux_ff[47] && !flux_zero;

   assign sts.last      = last_ff;
   assign sts.flux_pos  = flux_pos;
   assign sts.flux_zero = flux_zero;
   assign sts.norm_done = xs_ff[47];
   assign sts.out_free  = !ovalid_ff || rsp_ready;

   // saturating flux accumulate
   always_comb begin
      logic signed [48:0] s;
      s = {flux_ff[47], flux_ff} + 49'(pixel_value);
      if (s[48] != s[47]) flux_in = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      else flux_in = s[47:0];
   end

   always_comb begin
      logic [63:0] sq;
      sq = rms_ff * rms_ff;
      if (use_w_ff && w_abs_ff) bgv_in = 48'd1 << ifmu_pkg::FRAC_BITS;
      else bgv_in = sq[63:ifmu_pkg::FRAC_BITS];
   end

   always_comb begin
      logic [80:0] full;
      logic [64:0] sh;
      full = {phi_ff, 32'd0} + 81'(plo_ff);
      sh   = 65'(full >> ifmu_pkg::FRAC_BITS);
      if (!use_w_ff) var_in = 64'(bgv_ff);
      else if (full[80:64 + ifmu_pkg::FRAC_BITS] != '0) var_in = '1;
      else var_in = sh[63:0];
   end

   always_comb begin
      logic [64:0] s;
      s = {1'b0, vsum_ff} + {1'b0, var_ff};
      vsum_in = s[64] ? '1 : s[63:0];
   end

   assign srem_t = {srem_ff[40:0], sqop_ff[79:78]};
   assign strial = {1'b0, root_ff, 2'b01};
   assign msq    = m_ff * m_ff;
   assign lg     = {7'(signed'({1'b0, n_ff}) - 7'sd16), frac_ff};
   assign drem_t = {drem_ff, dvd_ff[87]};

   always_comb begin
      logic signed [63:0] h, r;
      logic signed [25:0] m;
      h = 64'sd1 <<< (ifmu_pkg::MAG_SHIFT - 1);
      if (!mprod_ff[63]) r = (mprod_ff + h) >>> ifmu_pkg::MAG_SHIFT;
      else r = -((-mprod_ff + h) >>> ifmu_pkg::MAG_SHIFT);
      m = 26'(zp_ff) - 26'(r);
      if (m > 26'sd8388607) mag_in = 24'sh7FFFFF;
      else if (m < -26'sd8388608) mag_in = 24'sh800000;
      else mag_in = m[23:0];
   end

   always_comb begin
      logic [39:0] qs;
      qs = q_ff[63:24];
      if (flux_zero) omerr_in = 32'sh7FFFFFFF;
      else if (flux_pos) omerr_in = (qsat_ff || qs > 40'h7FFFFFFF) ? 32'sh7FFFFFFF
                                                                   : signed'(qs[31:0]);
      else omerr_in = (qsat_ff || qs > 40'h80000000) ? 32'sh80000000
                                                     : signed'(~qs[31:0] + 32'd1);
   end

   // control state: registers, sums and the output slot
   always_ff @(posedge clock) begin
      if (reset) begin
         use_w_ff  <= 1'b0;
         w_abs_ff  <= 1'b0;
         rms_ff    <= 32'd65536;
         zp_ff     <= '0;
         flux_ff   <= '0;
         vsum_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ifmu_pkg::REG_USE_WEIGHT: use_w_ff <= csr_wdata[0];
               ifmu_pkg::REG_WEIGHT_ABS: w_abs_ff <= csr_wdata[0];
               ifmu_pkg::REG_BG_RMS:     rms_ff   <= csr_wdata;
               ifmu_pkg::REG_ZERO_POINT: zp_ff    <= signed'(csr_wdata[23:0]);
               default:                  use_w_ff <= use_w_ff;
            endcase
         end
         if (cmd.op == ifmu_pkg::OP_FINISH) ovalid_ff <= 1'b1;
         else if (rsp_ready) ovalid_ff <= 1'b0;
         case (cmd.op)
            ifmu_pkg::OP_LOAD: flux_ff <= flux_in;
            ifmu_pkg::OP_ACC:  vsum_ff <= vsum_in;
            ifmu_pkg::OP_FINISH: begin
               flux_ff <= '0;
               vsum_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         ifmu_pkg::OP_LOAD: begin
            w_ff    <= weight_value;
            last_ff <= last_pixel;
         end
         ifmu_pkg::OP_BGVAR: bgv_ff <= bgv_in;
         ifmu_pkg::OP_PROD: begin
            plo_ff <= bgv_ff[31:0] * w_ff;
            phi_ff <= bgv_ff[47:32] * w_ff;
         end
         ifmu_pkg::OP_VAR: var_ff <= var_in;
         ifmu_pkg::OP_SQRT_INIT: begin
            sqop_ff <= {vsum_ff, 16'd0};
            root_ff <= '0;
            srem_ff <= '0;
         end
         ifmu_pkg::OP_SQRT_STEP: begin
            sqop_ff <= {sqop_ff[77:0], 2'b00};
            if (srem_t >= strial) begin
               srem_ff <= srem_t - strial;
               root_ff <= {root_ff[38:0], 1'b1};
            end else begin
               srem_ff <= srem_t;
               root_ff <= {root_ff[38:0], 1'b0};
            end
         end
         ifmu_pkg::OP_NORM_INIT: begin
            xs_ff <= flux_ff;
            n_ff  <= 6'd47;
         end
         ifmu_pkg::OP_NORM_STEP: begin
            xs_ff <= {xs_ff[46:0], 1'b0};
            n_ff  <= n_ff - 6'd1;
         end
         ifmu_pkg::OP_LOG_INIT: begin
            m_ff    <= xs_ff[47:17];
            frac_ff <= '0;
         end
         ifmu_pkg::OP_LOG_STEP: begin
            // square the mantissa, renormalize into [1,2)
            if (msq[61]) begin
               m_ff    <= msq[61:31];
               frac_ff <= {frac_ff[22:0], 1'b1};
            end else begin
               m_ff    <= msq[60:30];
               frac_ff <= {frac_ff[22:0], 1'b0};
            end
         end
         ifmu_pkg::OP_MAG_MUL: mprod_ff <= 64'(lg) * 64'(signed'({1'b0, ifmu_pkg::MAG_PER_LOG2}));
         ifmu_pkg::OP_MAG_FIN: mag_ff <= mag_in;
         ifmu_pkg::OP_ERR_MUL: begin
            eph_ff <= root_ff[39:32] * ifmu_pkg::ERR_COEF;
            epl_ff <= root_ff[31:0] * ifmu_pkg::ERR_COEF;
         end
         ifmu_pkg::OP_ERR_COMB: begin
            dvd_ff  <= ({eph_ff, 32'd0} + 88'(epl_ff)) << ifmu_pkg::FRAC_BITS;
            d_ff    <= flux_ff[47] ? 48'(-flux_ff) : flux_ff;
            drem_ff <= '0;
            q_ff    <= '0;
            qsat_ff <= 1'b0;
         end
         ifmu_pkg::OP_DIV_STEP: begin
            dvd_ff <= {dvd_ff[86:0], 1'b0};
            if (q_ff[63:62] != 2'b00) qsat_ff <= 1'b1;
            if (drem_t >= {1'b0, d_ff}) begin
               drem_ff <= 48'(drem_t - {1'b0, d_ff});
               q_ff    <= {q_ff[62:0], 1'b1};
            end else begin
               drem_ff <= drem_t[47:0];
               q_ff    <= {q_ff[62:0], 1'b0};
            end
         end
         ifmu_pkg::OP_FINISH: begin
            oflux_ff <= flux_ff;
            oerr_ff  <= 47'(root_ff);
            omag_ff  <= flux_pos ? mag_ff : ifmu_pkg::MAG_NONE;
            omerr_ff <= omerr_in;
         end
         default: ;
      endcase
   end

   assign rsp_valid           = ovalid_ff;
   assign rsp_iso_flux        = oflux_ff;
   assign rsp_iso_flux_err    = oerr_ff;
   assign rsp_magnitude       = omag_ff;
   assign rsp_magnitude_error = omerr_ff;

   `IFMU_CHECK_NEXT(a_sums_cleared, cmd.op == ifmu_pkg::OP_FINISH,
                    flux_ff == '0 && vsum_ff == '0, "sums not cleared after result")
   `IFMU_CHECK_NEXT(a_div_rem, cmd.op == ifmu_pkg::OP_DIV_STEP, drem_ff < d_ff,
                    "divider remainder not below divisor")
   `IFMU_CHECK_NEXT(a_log_norm, cmd.op == ifmu_pkg::OP_LOG_STEP, m_ff[30],
                    "log mantissa left [1,2)")
   `IFMU_CHECK(a_out_hold, !(ovalid_ff && !rsp_ready && cmd.op == ifmu_pkg::OP_FINISH),
               "result overwrote a pending one")
endmodule
`default_nettype wire
